@@ sv/vcsd_pkg.sv @@
`default_nettype none

package vcsd_pkg;

    // Result kinds
    typedef logic [1:0] t_kind;
    localparam t_kind KIND_COLOR = 2'd0;
    localparam t_kind KIND_SPAN  = 2'd1;
    localparam t_kind KIND_DONE  = 2'd2;
    localparam t_kind KIND_ERROR = 2'd3;

    // Parser phase: span header bytes or colour bytes
    typedef enum logic [1:0] {
        PH_HEADER = 2'b01,
        PH_COLOR  = 2'b10
    } t_phase;

    // Byte position of the closing byte of a header or a colour
    localparam logic [1:0] POS_LAST = 2'd3;

    // Alpha is forced to have its two low bits set
    localparam logic [7:0] ALPHA_OR = 8'h03;

    // Results one byte can cause at most
    localparam int MAX_RES = 3;

    typedef struct packed {
        t_kind       kind;
        logic [19:0] column_index;
        logic [6:0]  slot;
        logic [31:0] color_word;
        logic [6:0]  span_top;
        logic [6:0]  span_bottom;
        logic        span_is_top;
        logic [7:0]  run_count;
        logic [6:0]  top_height;
        logic        last;
    } t_result;

    typedef struct packed {
        t_phase      phase;
        logic [1:0]  byte_pos;
        logic [7:0]  chunk;
        logic [7:0]  top_start;
        logic [7:0]  top_end;
        logic [8:0]  colors_rem;
        logic [7:0]  bottom_len;
        logic [23:0] color_bytes;
        logic [7:0]  color_slots;
        logic [7:0]  run_ctr;
        logic [6:0]  first_top;
        logic        first_span;
        logic        stream_done;
        logic        error_seen;
    } t_parse;

endpackage

`default_nettype wire

@@ sv/vcsd_step.sv @@
`default_nettype none

// Decode one stream byte against the parse state: next state and up to
// three result records.
module vcsd_step #(
    parameter int MAP_SIDE      = 512,
    parameter int COLUMN_HEIGHT = 64,
    parameter int RUN_SLOTS     = 128,
    parameter int COLOR_SLOTS   = 64,
    parameter int XW            = (MAP_SIDE > 1) ? $clog2(MAP_SIDE) : 1
) (
    input  wire vcsd_pkg::t_parse i_st,
    input  wire logic [XW-1:0] i_col_x,
    input  wire logic [XW-1:0] i_col_y,
    input  wire logic [7:0]    i_byte,
    output vcsd_pkg::t_parse  o_st,
    output logic [XW-1:0]      o_col_x,
    output logic [XW-1:0]      o_col_y,
    output vcsd_pkg::t_result o_res [vcsd_pkg::MAX_RES],
    output logic [1:0]         o_nres
);

    localparam logic [7:0]    RUN_LIM   = 8'(RUN_SLOTS);
    localparam logic [7:0]    COLOR_LIM = 8'(COLOR_SLOTS);
    localparam logic [6:0]    COL_H     = 7'(COLUMN_HEIGHT);
    localparam logic [XW-1:0] SIDE_LAST = XW'(MAP_SIDE - 1);

    logic [9:0]  sw_x;
    logic [9:0]  sw_y;
    logic [19:0] col_idx;

    logic [8:0]  te1;
    logic [8:0]  ts9;
    logic [8:0]  len_top;
    logic        chunk_nz;
    logic [8:0]  chunk_m1;
    logic [8:0]  total;
    logic [8:0]  rem_n;
    logic [31:0] color_word;

    vcsd_pkg::t_parse  st;
    vcsd_pkg::t_result res [vcsd_pkg::MAX_RES];
    logic [XW-1:0]     cx;
    logic [XW-1:0]     cy;
    logic [1:0]        nres;
    logic              fail;
    logic              do_finish;

    // Swizzled store index, rows flipped
    assign sw_x      = 10'(i_col_x);
    assign sw_y      = 10'(MAP_SIDE) - 10'(i_col_y);
    assign col_idx   = {sw_y[9:8], sw_x[9:8], sw_y[7:2], sw_x[7:2], sw_y[1:0], sw_x[1:0]};

    assign te1      = {1'b0, i_st.top_end} + 9'd1;
    assign ts9      = {1'b0, i_st.top_start};
    assign len_top  = te1 - ts9;
    assign chunk_nz = (i_st.chunk != 8'd0);
    assign chunk_m1 = {1'b0, i_st.chunk} - 9'd1;
    assign total    = chunk_nz ? chunk_m1 : len_top;
    assign rem_n    = i_st.colors_rem - 9'd1;
    assign color_word = {i_byte | vcsd_pkg::ALPHA_OR, i_st.color_bytes[7:0],
                         i_st.color_bytes[15:8], i_st.color_bytes[23:16]};

    function automatic vcsd_pkg::t_result span_rec(
        input logic [7:0]  run_i,
        input logic [6:0]  top_i,
        input logic [6:0]  bot_i,
        input logic        is_top_i,
        input logic [19:0] idx_i
    );
        vcsd_pkg::t_result r;
        r              = '0;
        r.kind         = vcsd_pkg::KIND_SPAN;
        r.column_index = idx_i;
        r.slot         = run_i[6:0];
        r.span_top     = top_i;
        r.span_bottom  = bot_i;
        r.span_is_top  = is_top_i;
        return r;
    endfunction

    always_comb begin
        st        = i_st;
        cx        = i_col_x;
        cy        = i_col_y;
        res       = '{default: '0};
        nres      = 2'd0;
        fail      = 1'b0;
        do_finish = 1'b0;

        if (!i_st.error_seen && !i_st.stream_done) begin
            unique case (i_st.phase)
                vcsd_pkg::PH_HEADER: begin
                    if (i_st.byte_pos != vcsd_pkg::POS_LAST) begin
                        case (i_st.byte_pos)
                            2'd0:    st.chunk     = i_byte;
                            2'd1:    st.top_start = i_byte;
                            default: st.top_end   = i_byte;
                        endcase
                        st.byte_pos = i_st.byte_pos + 2'd1;
                    end else begin
                        // Air start byte: close the pending bottom span first
                        if (!i_st.first_span) begin
                            if (i_byte < i_st.bottom_len) begin
                                fail = 1'b1;
                            end else if (st.run_ctr >= RUN_LIM) begin
                                fail = 1'b1;
                            end else begin
                                res[nres] = span_rec(st.run_ctr,
                                                     7'(i_byte - i_st.bottom_len),
                                                     i_byte[6:0], 1'b0, col_idx);
                                nres       = nres + 2'd1;
                                st.run_ctr = st.run_ctr + 8'd1;
                            end
                        end
                        if (!fail && te1 < ts9) begin
                            fail = 1'b1;
                        end
                        if (!fail && chunk_nz && chunk_m1 < len_top) begin
                            fail = 1'b1;
                        end
                        if (i_st.first_span) begin
                            st.first_top  = i_st.top_start[6:0];
                            st.first_span = 1'b0;
                        end
                        st.bottom_len = chunk_nz ? 8'(total - len_top) : 8'd0;
                        st.colors_rem = total;
                        st.byte_pos   = 2'd0;
                        if (total != 9'd0) begin
                            st.phase = vcsd_pkg::PH_COLOR;
                        end
                        if (len_top == 9'd0) begin
                            do_finish = 1'b1;
                        end
                    end
                end
                vcsd_pkg::PH_COLOR: begin
                    if (i_st.byte_pos != vcsd_pkg::POS_LAST) begin
                        case (i_st.byte_pos)
                            2'd0:    st.color_bytes        = {16'h0000, i_byte};
                            2'd1:    st.color_bytes[15:8]  = i_byte;
                            default: st.color_bytes[23:16] = i_byte;
                        endcase
                        st.byte_pos = i_st.byte_pos + 2'd1;
                    end else begin
                        st.byte_pos = 2'd0;
                        if (i_st.color_slots >= COLOR_LIM) begin
                            fail = 1'b1;
                        end else begin
                            res[nres]              = '0;
                            res[nres].kind         = vcsd_pkg::KIND_COLOR;
                            res[nres].column_index = col_idx;
                            res[nres].slot         = i_st.color_slots[6:0];
                            res[nres].color_word   = color_word;
                            nres           = nres + 2'd1;
                            st.color_slots = i_st.color_slots + 8'd1;
                            st.colors_rem  = rem_n;
                            // Last top colour closes the top span
                            if ((i_st.colors_rem > {1'b0, i_st.bottom_len})
                                    && (rem_n == {1'b0, i_st.bottom_len})) begin
                                do_finish = 1'b1;
                            end
                            if (rem_n == 9'd0) begin
                                st.phase = vcsd_pkg::PH_HEADER;
                            end
                        end
                    end
                end
                default: begin
                    st.phase = vcsd_pkg::PH_HEADER;
                end
            endcase

            if (do_finish && !fail) begin
                if (st.run_ctr >= RUN_LIM) begin
                    fail = 1'b1;
                end else if (chunk_nz) begin
                    res[nres] = span_rec(st.run_ctr, i_st.top_start[6:0],
                                         i_st.top_end[6:0] + 7'd1, 1'b1, col_idx);
                    nres       = nres + 2'd1;
                    st.run_ctr = st.run_ctr + 8'd1;
                end else begin
                    // Last span of the column: bottom at column height, then done
                    res[nres] = span_rec(st.run_ctr, i_st.top_start[6:0],
                                         COL_H, 1'b1, col_idx);
                    nres       = nres + 2'd1;
                    st.run_ctr = st.run_ctr + 8'd1;

                    res[nres]              = '0;
                    res[nres].kind         = vcsd_pkg::KIND_DONE;
                    res[nres].column_index = col_idx;
                    res[nres].run_count    = st.run_ctr;
                    res[nres].top_height   = st.first_top;
                    nres = nres + 2'd1;

                    st.run_ctr     = 8'd0;
                    st.color_slots = 8'd0;
                    st.first_span  = 1'b1;
                    st.first_top   = 7'd0;
                    if (i_col_x == SIDE_LAST) begin
                        cx = '0;
                        if (i_col_y == SIDE_LAST) begin
                            st.stream_done = 1'b1;
                        end else begin
                            cy = i_col_y + XW'(1);
                        end
                    end else begin
                        cx = i_col_x + XW'(1);
                    end
                end
            end

            // An error is the only result of its byte
            if (fail) begin
                st               = i_st;
                st.error_seen    = 1'b1;
                cx               = i_col_x;
                cy               = i_col_y;
                res              = '{default: '0};
                res[0].kind      = vcsd_pkg::KIND_ERROR;
                res[0].column_index = col_idx;
                nres             = 2'd1;
            end
        end

        for (int i = 0; i < vcsd_pkg::MAX_RES; i++) begin
            res[i].last = (2'(i + 1) == nres);
        end
    end

    assign o_st    = st;
    assign o_col_x = cx;
    assign o_col_y = cy;
    assign o_res   = res;
    assign o_nres  = nres;

endmodule

`default_nettype wire

@@ sv/vxl_column_span_decoder.sv @@
`default_nettype none
// Path: a byte's first result beat passes the input register, then the result bank loaded
//   by the decoder, before the receiver can take it.
// Throughput: one byte per cycle while each byte yields at most one beat and the receiver
//   does not stall; a byte with more beats (up to 3) holds the input register as the bank drains.
// Reset: synchronous, active low; clears the parse state, the column position and
//   both handshake stages. No clearing pass follows.

module vxl_column_span_decoder #(
    parameter int MAP_SIDE      = 512,
    parameter int COLUMN_HEIGHT = 64,
    parameter int RUN_SLOTS     = 128,
    parameter int COLOR_SLOTS   = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    // Byte stream in
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_data_byte,

    // Result beats out
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_kind,
    output logic [19:0]      o_column_index,
    output logic [6:0]       o_slot,
    output logic [31:0]      o_color_word,
    output logic [6:0]       o_span_top,
    output logic [6:0]       o_span_bottom,
    output logic             o_span_is_top,
    output logic [7:0]       o_run_count,
    output logic [6:0]       o_top_height,
    output logic             o_last
);

    localparam int XW = (MAP_SIDE > 1) ? $clog2(MAP_SIDE) : 1;

    // Parse state after reset: header phase, first span of a column pending
    localparam vcsd_pkg::t_parse ST_RESET = '{phase: vcsd_pkg::PH_HEADER,
                                              first_span: 1'b1, default: '0};

    // Input register: holds one byte while the result bank still drains
    logic              r_in_valid;
    logic [7:0]        r_in_byte;

    // Parse state and column position
    vcsd_pkg::t_parse  r_st;
    logic [XW-1:0]     r_col_x;
    logic [XW-1:0]     r_col_y;

    // Result bank: the results of one byte, read out in order
    vcsd_pkg::t_result r_bank [vcsd_pkg::MAX_RES];
    logic [1:0]        r_cnt;
    logic [1:0]        r_rd;

    vcsd_pkg::t_parse  n_st;
    logic [XW-1:0]     n_col_x;
    logic [XW-1:0]     n_col_y;
    vcsd_pkg::t_result n_res [vcsd_pkg::MAX_RES];
    logic [1:0]        n_nres;

    logic              out_take;
    logic              bank_free;
    logic              load;
    logic              in_take;
    vcsd_pkg::t_result head;

    vcsd_step #(
        .MAP_SIDE      (MAP_SIDE),
        .COLUMN_HEIGHT (COLUMN_HEIGHT),
        .RUN_SLOTS     (RUN_SLOTS),
        .COLOR_SLOTS   (COLOR_SLOTS),
        .XW            (XW)
    ) u_step (
        .i_st    (r_st),
        .i_col_x (r_col_x),
        .i_col_y (r_col_y),
        .i_byte  (r_in_byte),
        .o_st    (n_st),
        .o_col_x (n_col_x),
        .o_col_y (n_col_y),
        .o_res   (n_res),
        .o_nres  (n_nres)
    );

    // The bank takes a new byte's results once its last beat leaves
    assign out_take  = o_valid && !i_stall;
    assign bank_free = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && out_take);
    assign load      = r_in_valid && bank_free;
    assign o_stall   = r_in_valid && !bank_free;
    assign in_take   = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (load) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_data_byte;
        end
    end

    // Advance the parse state once per byte, as it enters the bank
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= ST_RESET;
            r_col_x <= '0;
            r_col_y <= '0;
        end else if (load) begin
            r_st    <= n_st;
            r_col_x <= n_col_x;
            r_col_y <= n_col_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rd  <= 2'd0;
        end else if (load) begin
            r_cnt <= n_nres;
            r_rd  <= 2'd0;
        end else if (out_take) begin
            r_cnt <= r_cnt - 2'd1;
            r_rd  <= r_rd + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_bank <= n_res;
        end
    end

    assign head           = r_bank[r_rd];
    assign o_valid        = (r_cnt != 2'd0);
    assign o_kind         = head.kind;
    assign o_column_index = head.column_index;
    assign o_slot         = head.slot;
    assign o_color_word   = head.color_word;
    assign o_span_top     = head.span_top;
    assign o_span_bottom  = head.span_bottom;
    assign o_span_is_top  = head.span_is_top;
    assign o_run_count    = head.run_count;
    assign o_top_height   = head.top_height;
    assign o_last         = head.last;

endmodule

`default_nettype wire

@@ sv/vcsd_checker.sv @@
`default_nettype none

module vcsd_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [1:0]  o_kind,
    input wire logic [19:0] o_column_index,
    input wire logic [31:0] o_color_word,
    input wire logic [7:0]  o_run_count,
    input wire logic        o_last
);

    // A stalled beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_kind)
            && $stable(o_column_index) && $stable(o_color_word) && $stable(o_last)))
        else $error("result beat changed while stalled");

    // Nothing follows a taken error beat until reset
    a_err_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && (o_kind == vcsd_pkg::KIND_ERROR)) |=> !o_valid)
        else $error("result after format error");

    // Error and column done close their byte
    a_close_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && ((o_kind == vcsd_pkg::KIND_ERROR) || (o_kind == vcsd_pkg::KIND_DONE)))
            |-> o_last)
        else $error("error or done beat not marked last");

    // A finished column always holds its top span
    a_done_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_kind == vcsd_pkg::KIND_DONE)) |-> (o_run_count != 8'd0))
        else $error("column done with no span records");

endmodule

bind vxl_column_span_decoder vcsd_checker u_vcsd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_kind         (o_kind),
    .o_column_index (o_column_index),
    .o_color_word   (o_color_word),
    .o_run_count    (o_run_count),
    .o_last         (o_last)
);

`default_nettype wire

@@ test/testbench.sv @@
`default_nettype none

module testbench;

    // Geometry the block is built with; the predictor works to the same numbers.
    localparam int MAP_SIDE      = 512;
    localparam int COLUMN_HEIGHT = 64;
    localparam int RUN_SLOTS     = 128;
    localparam int COLOR_SLOTS   = 64;

    // Header byte positions before the closing air-start byte.
    localparam int HDR_CHUNKS    = 0;
    localparam int HDR_TOP_START = 1;

    // Slack for the input register and the result bank, with up to three beats in it.
    localparam int END_SLACK   = 16;
    localparam int CYCLE_LIMIT = 600000;
    localparam int PRINT_LIMIT = 40;

    // Ways to break the stream in the closing test.
    typedef enum int {
        BAD_NEG_TOP,
        BAD_FEW_CHUNKS,
        BAD_BOTTOM_BELOW
    } t_bad_stream;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_stall     = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [1:0]  o_kind;
    logic [19:0] o_column_index;
    logic [6:0]  o_slot;
    logic [31:0] o_color_word;
    logic [6:0]  o_span_top;
    logic [6:0]  o_span_bottom;
    logic        o_span_is_top;
    logic [7:0]  o_run_count;
    logic [6:0]  o_top_height;
    logic        o_last;

    vxl_column_span_decoder #(
        .MAP_SIDE      (MAP_SIDE),
        .COLUMN_HEIGHT (COLUMN_HEIGHT),
        .RUN_SLOTS     (RUN_SLOTS),
        .COLOR_SLOTS   (COLOR_SLOTS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_data_byte    (i_data_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_kind         (o_kind),
        .o_column_index (o_column_index),
        .o_slot         (o_slot),
        .o_color_word   (o_color_word),
        .o_span_top     (o_span_top),
        .o_span_bottom  (o_span_bottom),
        .o_span_is_top  (o_span_is_top),
        .o_run_count    (o_run_count),
        .o_top_height   (o_top_height),
        .o_last         (o_last)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Bookkeeping
    // ------------------------------------------------------------------
    int cycle_count = 0;
    int fail_count  = 0;
    int beats_seen  = 0;
    int bytes_sent  = 0;

    // Traffic knobs, set per test.
    bit gaps_on    = 1'b1;
    int gap_max    = 4;
    int burst_left = 0;
    int stall_pct  = 0;
    int stall_hold = 0;

    // Expected result beats, oldest first, and the beats of the byte in progress.
    vcsd_pkg::t_result pending_beats[$];
    vcsd_pkg::t_result beats_of_byte[$];

    // ------------------------------------------------------------------
    // Decoder state as the predictor sees it
    // ------------------------------------------------------------------
    vcsd_pkg::t_phase phase       = vcsd_pkg::PH_HEADER;
    int          byte_pos         = 0;
    int          span_chunks      = 0;
    int          span_top_start   = 0;
    int          span_top_end     = 0;
    int          colors_left      = 0;
    int          bottom_len       = 0;
    logic [23:0] color_acc        = '0;
    int          color_slots_used = 0;
    int          runs_in_column   = 0;
    logic [6:0]  column_first_top = '0;
    bit          column_fresh     = 1'b1;
    int          col_x            = 0;
    int          col_y            = 0;
    bit          stream_finished  = 1'b0;
    bit          stream_halted    = 1'b0;

    task automatic report_error(input string msg);
        fail_count++;
        if (fail_count <= PRINT_LIMIT) $display("ERROR cycle %0d: %s", cycle_count, msg);
    endtask

    // Rows are flipped, then x and y are split into tile, 4x4 block and offset.
    function automatic logic [19:0] swizzled_index();
        logic [9:0] x;
        logic [9:0] y;
        x = col_x[9:0];
        y = 10'(MAP_SIDE - col_y);
        return {y[9:8], x[9:8], y[7:2], x[7:2], y[1:0], x[1:0]};
    endfunction

    function automatic vcsd_pkg::t_result blank_beat(input vcsd_pkg::t_kind kind);
        vcsd_pkg::t_result r;
        r = '0;
        r.kind = kind;
        r.column_index = swizzled_index();
        return r;
    endfunction

    // Queue a span record; refuse once the column has used every run slot.
    function automatic bit add_span_beat(input int top, input int bottom, input bit is_top);
        vcsd_pkg::t_result r;
        if (runs_in_column >= RUN_SLOTS) return 1'b0;
        r = blank_beat(vcsd_pkg::KIND_SPAN);
        r.slot        = 7'(runs_in_column);
        r.span_top    = 7'(top);
        r.span_bottom = 7'(bottom);
        r.span_is_top = is_top;
        beats_of_byte.push_back(r);
        runs_in_column++;
        return 1'b1;
    endfunction

    // Close the top part of a span. The last span of a column ends at the column
    // height and closes the column too: done beat, counters cleared, step to the
    // next column.
    function automatic bit close_top_span();
        vcsd_pkg::t_result r;
        if (span_chunks != 0) return add_span_beat(span_top_start, span_top_end + 1, 1'b1);
        if (!add_span_beat(span_top_start, COLUMN_HEIGHT, 1'b1)) return 1'b0;
        r = blank_beat(vcsd_pkg::KIND_DONE);
        r.run_count  = 8'(runs_in_column);
        r.top_height = column_first_top;
        beats_of_byte.push_back(r);
        runs_in_column   = 0;
        color_slots_used = 0;
        column_fresh     = 1'b1;
        column_first_top = '0;
        col_x++;
        if (col_x >= MAP_SIDE) begin
            col_x = 0;
            col_y++;
            if (col_y >= MAP_SIDE) stream_finished = 1'b1;
        end
        return 1'b1;
    endfunction

    // Advance the parse by one byte; return 0 on a format error.
    function automatic bit parse_byte(input logic [7:0] b);
        int      bi;
        int      len_top;
        int      total;
        bit      was_top;
        vcsd_pkg::t_result r;
        bi = int'(b);
        if (phase == vcsd_pkg::PH_HEADER) begin
            if (byte_pos != int'(vcsd_pkg::POS_LAST)) begin
                if (byte_pos == HDR_CHUNKS) span_chunks = bi;
                else if (byte_pos == HDR_TOP_START) span_top_start = bi;
                else span_top_end = bi;
                byte_pos++;
                return 1'b1;
            end
            byte_pos = 0;
            // The air start byte places the bottom of the previous span.
            if (!column_fresh) begin
                if (bi < bottom_len) return 1'b0;
                if (!add_span_beat(bi - bottom_len, bi, 1'b0)) return 1'b0;
            end
            if (span_top_end + 1 < span_top_start) return 1'b0;
            len_top = span_top_end + 1 - span_top_start;
            if (span_chunks != 0 && span_chunks - 1 < len_top) return 1'b0;
            if (column_fresh) begin
                column_first_top = 7'(span_top_start);
                column_fresh = 1'b0;
            end
            total       = (span_chunks != 0) ? span_chunks - 1 : len_top;
            bottom_len  = (span_chunks != 0) ? total - len_top : 0;
            colors_left = total;
            if (len_top == 0 && !close_top_span()) return 1'b0;
            if (total > 0) phase = vcsd_pkg::PH_COLOR;
            return 1'b1;
        end
        if (byte_pos != int'(vcsd_pkg::POS_LAST)) begin
            color_acc[8*byte_pos +: 8] = b;
            byte_pos++;
            return 1'b1;
        end
        byte_pos = 0;
        if (color_slots_used >= COLOR_SLOTS) return 1'b0;
        r = blank_beat(vcsd_pkg::KIND_COLOR);
        r.slot = 7'(color_slots_used);
        r.color_word = {b | vcsd_pkg::ALPHA_OR, color_acc[7:0], color_acc[15:8],
                        color_acc[23:16]};
        beats_of_byte.push_back(r);
        color_slots_used++;
        was_top = colors_left > bottom_len;
        colors_left--;
        if (was_top && colors_left == bottom_len && !close_top_span()) return 1'b0;
        if (colors_left == 0) phase = vcsd_pkg::PH_HEADER;
        return 1'b1;
    endfunction

    // Work out the beats an accepted byte causes and queue them for the checker.
    task automatic predict_byte(input logic [7:0] b);
        beats_of_byte.delete();
        if (stream_halted || stream_finished) return;
        if (!parse_byte(b)) begin
            // An error replaces whatever the byte had produced and halts the stream.
            beats_of_byte.delete();
            beats_of_byte.push_back(blank_beat(vcsd_pkg::KIND_ERROR));
            stream_halted = 1'b1;
        end
        if (beats_of_byte.size() != 0) beats_of_byte[beats_of_byte.size() - 1].last = 1'b1;
        foreach (beats_of_byte[k]) pending_beats.push_back(beats_of_byte[k]);
    endtask

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------
    task automatic set_traffic(input bit gaps, input int gap_limit, input int stall_percent);
        gaps_on   = gaps;
        gap_max   = gap_limit;
        stall_pct = stall_percent;
    endtask

    // Offer one byte and hold it until the block takes it. Bursts end in a gap
    // of random length; with gaps off, valid stays high from byte to byte.
    task automatic send_byte(input logic [7:0] b);
        i_valid     <= 1'b1;
        i_data_byte <= b;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        predict_byte(b);
        bytes_sent++;
        if (gaps_on && burst_left == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(gap_max, 1)) @(posedge i_clk);
            burst_left = $urandom_range(16);
        end else if (burst_left > 0) begin
            burst_left--;
        end
    endtask

    // Colours travel little-endian: blue, green, red, alpha.
    task automatic send_color(input logic [31:0] bgra);
        send_byte(bgra[7:0]);
        send_byte(bgra[15:8]);
        send_byte(bgra[23:16]);
        send_byte(bgra[31:24]);
    endtask

    task automatic send_header(input int chunks, input int top_start, input int top_end,
                               input int air);
        send_byte(8'(chunks));
        send_byte(8'(top_start));
        send_byte(8'(top_end));
        send_byte(8'(air));
    endtask

    // A well-formed column: a few spans with short random top and bottom runs,
    // closed by a last span.
    task automatic send_random_column();
        int n_spans;
        int top_len;
        int bot_len;
        int ts;
        int air;
        int prev_bot;
        prev_bot = 0;
        n_spans = $urandom_range(5, 1);
        for (int k = 0; k < n_spans; k++) begin
            top_len = $urandom_range(3);
            if (k == n_spans - 1) bot_len = 0;
            else if ($urandom_range(7) == 0) bot_len = $urandom_range(10);
            else bot_len = $urandom_range(2);
            ts  = (top_len == 0) ? $urandom_range(255, 1) : $urandom_range(256 - top_len);
            air = ($urandom_range(3) == 0) ? prev_bot : $urandom_range(255, prev_bot);
            send_header((k == n_spans - 1) ? 0 : top_len + bot_len + 1, ts, ts + top_len - 1,
                        air);
            repeat (top_len + bot_len) send_color($urandom);
            prev_bot = bot_len;
        end
    endtask

    // Last span with no top colours: span and done beats on the air byte.
    task automatic send_empty_column();
        int ts;
        ts = $urandom_range(255, 1);
        send_header(0, ts, ts - 1, $urandom_range(255));
    endtask

    // Drop valid and hold until every expected beat has come back.
    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_beats.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Receiver: stall in dwells of random length, at a per-test density.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || stall_pct == 0) begin
            i_stall    <= 1'b0;
            stall_hold <= 0;
        end else if (stall_hold == 0) begin
            i_stall    <= ($urandom_range(99) < stall_pct);
            stall_hold <= $urandom_range(7);
        end else begin
            stall_hold <= stall_hold - 1;
        end
    end

    // ------------------------------------------------------------------
    // Checker: every accepted beat against the oldest expectation.
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_error($sformatf("beat %0d %s: got 0x%0h, want 0x%0h",
                                   beats_seen, name, got, want));
    endtask

    always @(posedge i_clk) begin : beat_checker
        vcsd_pkg::t_result want;
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (pending_beats.size() == 0) begin
                report_error($sformatf("beat %0d of kind %0d with nothing expected",
                                       beats_seen, o_kind));
            end else begin
                want = pending_beats.pop_front();
                check_field("kind", 32'(o_kind), 32'(want.kind));
                check_field("column_index", 32'(o_column_index), 32'(want.column_index));
                check_field("slot", 32'(o_slot), 32'(want.slot));
                check_field("color_word", o_color_word, want.color_word);
                check_field("span_top", 32'(o_span_top), 32'(want.span_top));
                check_field("span_bottom", 32'(o_span_bottom), 32'(want.span_bottom));
                check_field("span_is_top", 32'(o_span_is_top), 32'(want.span_is_top));
                check_field("run_count", 32'(o_run_count), 32'(want.run_count));
                check_field("top_height", 32'(o_top_height), 32'(want.top_height));
                check_field("last", 32'(o_last), 32'(want.last));
            end
            beats_seen++;
        end
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("vxl_column_span_decoder regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Hand-built columns: all-ones and all-zeros colours, a span with top and
    // bottom colours, a bottom placed by the next header, an empty last span
    // giving three beats on one byte, a span with no colours at all, a bottom
    // of zero length, and tops past 127.
    task automatic test_directed_spans();
        set_traffic(1'b1, 3, 30);
        send_header(3, 10, 10, 5);
        send_color(32'hFFFF_FFFF);
        send_color(32'h0000_0000);
        send_header(0, 20, 19, 40);
        send_header(1, 5, 4, 255);
        send_header(0, 127, 128, 0);
        send_color(32'h807F_01FE);
        send_color(32'h5A5A_A5A5);
        send_header(0, 255, 254, 0);
    endtask

    // No gaps and no stalls: one byte per cycle where the bank allows it.
    task automatic test_unthrottled();
        int start;
        start = bytes_sent;
        set_traffic(1'b0, 1, 0);
        while (bytes_sent - start < 30) send_random_column();
    endtask

    // Pause after each column until the block has emptied, under back pressure.
    task automatic test_drain_pause();
        set_traffic(1'b1, 3, 40);
        repeat (2) begin
            send_random_column();
            drain_results();
        end
    endtask

    // Walk a run of minimal columns so that the store index steps through the
    // low x bits.
    task automatic test_column_walk();
        set_traffic(1'b1, 2, 20);
        repeat (8) send_empty_column();
    endtask

    // Random well-formed columns with traffic reshuffled per column.
    task automatic test_random_columns();
        int start;
        start = bytes_sent;
        while (bytes_sent - start < 30) begin
            set_traffic($urandom_range(1), $urandom_range(8, 1), 25 * $urandom_range(3));
            send_random_column();
        end
    endtask

    // One malformed stream, picked at random since only reset clears the error;
    // the bytes after it must be dropped without a beat.
    task automatic test_format_error();
        t_bad_stream bad;
        bad = t_bad_stream'($urandom_range(BAD_BOTTOM_BELOW));
        set_traffic(1'b1, 4, 30);
        send_empty_column();
        case (bad)
            BAD_NEG_TOP: begin
                send_header(2, 200, 100, 0);
            end
            BAD_FEW_CHUNKS: begin
                send_header(2, 10, 12, 0);
            end
            default: begin
                send_header(4, 10, 10, 0);
                repeat (3) send_color($urandom);
                send_header(0, 20, 19, 1);
            end
        endcase
        repeat (8) send_byte(8'($urandom_range(255)));
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_spans();
        test_unthrottled();
        test_drain_pause();
        test_column_walk();
        test_random_columns();
        test_format_error();

        // Let the last beats out, then watch for strays.
        drain_results();
        repeat (END_SLACK) @(posedge i_clk);
        if (pending_beats.size() != 0)
            report_error($sformatf("%0d expected beats never arrived", pending_beats.size()));

        if (fail_count == 0) begin
            $display("vxl_column_span_decoder regression: pass");
        end else begin
            $display("vxl_column_span_decoder regression: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
